@@ rtl/tcw_pkg.sv @@
// shared constants and types for the text console writer
package tcw_pkg;

    // screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int COPY_CELLS  = CELL_COUNT - SCREEN_COLS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int ROW_W       = $clog2(SCREEN_ROWS);
    localparam int COL_W       = $clog2(SCREEN_COLS);

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // character and attribute codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    // one input item
    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_item;

    // screen store access request
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [15:0]       wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    // finished result from the sequencer
    typedef struct packed {
        logic       valid;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic       scrolled;
    } t_result;

endpackage

@@ rtl/tcw_screen_ram.sv @@
// screen cell store: one write port, one registered read port
module tcw_screen_ram (
    input  logic              i_clk,
    input  tcw_pkg::t_ram_req i_req,
    output logic [15:0]       o_rd_data
);
    import tcw_pkg::*;

    logic [15:0] r_mem [CELL_COUNT];
    logic [15:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/tcw_sequencer.sv @@
// cursor state, shared address unit and sequencer for puts, reads, scroll and clear
module tcw_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  tcw_pkg::t_item    i_item,
    output logic              o_item_ready,
    input  logic [7:0]        i_attr,
    input  logic              i_slot_free,
    input  logic [15:0]       i_rd_data,
    output tcw_pkg::t_ram_req o_ram_req,
    output tcw_pkg::t_result  o_result
);
    import tcw_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        r_state,    n_state;
    logic [ADDR_W-1:0] r_cnt,      n_cnt;
    logic [ROW_W-1:0]  r_row,      n_row;
    logic [COL_W-1:0]  r_col,      n_col;
    logic              r_func,     n_func;
    logic              r_hit,      n_hit;
    logic              r_scrolled, n_scrolled;
    logic              r_wpend,    n_wpend;
    logic [ADDR_W-1:0] r_wdst,     n_wdst;

    logic [ADDR_W-1:0] u_row;
    logic [ADDR_W-1:0] u_off;
    logic [ADDR_W-1:0] u_addr;

    logic              w_accept;
    logic              w_is_nl;
    logic              w_hit;
    logic              w_col_last;
    logic              w_row_last;
    logic              w_row_inc;
    logic              w_scroll;
    logic [COL_W-1:0]  w_col_put;
    logic [ROW_W-1:0]  w_row_put;

    // shared address unit: row times width plus offset
    assign u_addr = ADDR_W'(u_row * ADDR_W'(SCREEN_COLS) + u_off);

    // put and read decode
    assign w_accept   = i_item_valid && (r_state == S_IDLE);
    assign w_is_nl    = (i_item.char_code == NEWLINE_CODE);
    assign w_hit      = (32'(i_item.read_row) < SCREEN_ROWS)
                     && (32'(i_item.read_col) < SCREEN_COLS);
    assign w_col_last = (r_col == COL_W'(SCREEN_COLS - 1));
    assign w_row_last = (r_row == ROW_W'(SCREEN_ROWS - 1));
    assign w_row_inc  = w_is_nl || w_col_last;
    assign w_scroll   = w_row_inc && w_row_last;
    assign w_col_put  = w_row_inc ? '0 : COL_W'(r_col + 1'b1);
    assign w_row_put  = (w_row_inc && !w_row_last) ? ROW_W'(r_row + 1'b1) : r_row;

    // next state and store requests
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_func     = r_func;
        n_hit      = r_hit;
        n_scrolled = r_scrolled;
        n_wpend    = r_wpend;
        n_wdst     = r_wdst;
        u_row      = '0;
        u_off      = '0;
        o_ram_req  = '0;
        case (r_state)
            S_CLEAR: begin
                u_off             = r_cnt;
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = u_addr;
                o_ram_req.wr_data = {RESET_ATTR, SPACE_CODE};
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = ADDR_W'(r_cnt + 1'b1);
                end
            end
            S_IDLE: begin
                if (i_item.func) begin
                    u_row = ADDR_W'(i_item.read_row);
                    u_off = ADDR_W'(i_item.read_col);
                end else begin
                    u_row = ADDR_W'(r_row);
                    u_off = ADDR_W'(r_col);
                end
                if (w_accept) begin
                    n_func     = i_item.func;
                    n_hit      = w_hit;
                    n_scrolled = 1'b0;
                    n_wpend    = 1'b0;
                    n_cnt      = '0;
                    if (i_item.func) begin
                        o_ram_req.rd_en   = w_hit;
                        o_ram_req.rd_addr = u_addr;
                        n_state           = S_DONE;
                    end else begin
                        o_ram_req.wr_en   = !w_is_nl;
                        o_ram_req.wr_addr = u_addr;
                        o_ram_req.wr_data = {i_attr, i_item.char_code};
                        n_col             = w_col_put;
                        n_row             = w_row_put;
                        n_scrolled        = w_scroll;
                        n_state           = w_scroll ? S_COPY : S_DONE;
                    end
                end
            end
            S_COPY: begin
                // read one row ahead, write the cell read in the cycle before
                u_row             = ADDR_W'(1);
                u_off             = r_cnt;
                o_ram_req.wr_en   = r_wpend;
                o_ram_req.wr_addr = r_wdst;
                o_ram_req.wr_data = i_rd_data;
                if (r_cnt == ADDR_W'(COPY_CELLS)) begin
                    n_wpend = 1'b0;
                    n_state = S_FILL;
                end else begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = u_addr;
                    n_wdst            = r_cnt;
                    n_wpend           = 1'b1;
                    n_cnt             = ADDR_W'(r_cnt + 1'b1);
                end
            end
            S_FILL: begin
                u_off             = r_cnt;
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = u_addr;
                o_ram_req.wr_data = {i_attr, SPACE_CODE};
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = ADDR_W'(r_cnt + 1'b1);
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_func     <= 1'b0;
            r_hit      <= 1'b0;
            r_scrolled <= 1'b0;
            r_wpend    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
            r_func     <= n_func;
            r_hit      <= n_hit;
            r_scrolled <= n_scrolled;
            r_wpend    <= n_wpend;
        end
    end

    // copy destination, payload only
    always_ff @(posedge i_clk) begin
        r_wdst <= n_wdst;
    end

    // handshake and result
    assign o_item_ready = (r_state == S_IDLE);

    always_comb begin
        o_result            = '0;
        o_result.valid      = (r_state == S_DONE);
        o_result.cell_char  = (r_func && r_hit) ? i_rd_data[7:0]  : 8'd0;
        o_result.cell_attr  = (r_func && r_hit) ? i_rd_data[15:8] : 8'd0;
        o_result.cursor_row = 5'(r_row);
        o_result.cursor_col = 7'(r_col);
        o_result.scrolled   = r_scrolled;
    end

endmodule

@@ rtl/text_console_writer_core.sv @@
// top level of the text console writer: stream ports, attribute register, output register
//
// Character-cell text console with an 80 by 25 store of 16-bit cells (character in
// the low byte, attribute in the high byte) and a cursor. Each input transfer is a
// put (tuser 0) or a cell read (tuser 1) and gives exactly one result transfer.
// In a put or a read the store access happens in the accepting cycle, and the result
// is loaded into the output register once that register is free. A put that runs
// past the last row scrolls the screen: the store's write and read ports copy one cell
// per cycle, one read ahead of the write, and then fill the bottom row. A stalled
// output register holds the finished result and the input waits until it drains.
// After reset the store is cleared to grey spaces in a pass over every cell, during
// which no input is accepted. Attribute writes on the configuration channel are
// always taken and apply from the next store write, so they belong between items.
module text_console_writer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // char_code [7:0], read_row [12:8], read_col [19:13], zero [23:20]
    input  logic [tcw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func [0]
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // cell_char [7:0], cell_attr [15:8], cursor_row [20:16], cursor_col [27:21],
    // scrolled [28], zero [31:29]
    output logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [7:0]                     i_cfg_data
);
    import tcw_pkg::*;

    logic [7:0]            r_attr;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_item                 w_item;
    t_ram_req              w_ram_req;
    t_result               w_res;
    logic [15:0]           w_rd_data;
    logic                  w_slot_free;

    // attribute register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    // unpack the input transfer
    always_comb begin
        w_item.func      = s_axis_tuser[0];
        w_item.char_code = s_axis_tdata[7:0];
        w_item.read_row  = s_axis_tdata[12:8];
        w_item.read_col  = s_axis_tdata[19:13];
    end

    tcw_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .i_item       (w_item),
        .o_item_ready (s_axis_tready),
        .i_attr       (r_attr),
        .i_slot_free  (w_slot_free),
        .i_rd_data    (w_rd_data),
        .o_ram_req    (w_ram_req),
        .o_result     (w_res)
    );

    tcw_screen_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_ram_req),
        .o_rd_data (w_rd_data)
    );

    // output register
    assign w_slot_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res.valid) begin
            r_out_data <= {3'b000, w_res.scrolled, w_res.cursor_col, w_res.cursor_row,
                           w_res.cell_attr, w_res.cell_char};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // one item at a time: no transfer in the cycle after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in consecutive cycles");

    // a scroll always leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[28] |-> m_axis_tdata[20:16] == 5'(SCREEN_ROWS - 1))
        else $error("scroll result not on the last row");

    // a finished result reaches the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid && w_slot_free |=> m_axis_tvalid)
        else $error("finished result not presented");
`endif

endmodule
